// ----- hdl/drd_pkg.sv -----
package drd_pkg;

  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ROW_IDX_W  = 9;
  localparam int TALLY_W    = 10;
  localparam int MIN_SIZE   = 8;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST   = 10'd320;
  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST   = 10'd480;
  localparam logic [1:0]            NOISE_LEVEL_RST = 2'd1;

  localparam logic [PIX_W-1:0] PIXEL_ONES = 16'hFFFF;

  localparam logic [1:0] NOISE_NONE = 2'd0;
  localparam logic [1:0] NOISE_LOW1 = 2'd1;
  localparam logic [1:0] NOISE_LOW2 = 2'd2;
  localparam logic [1:0] NOISE_LOW3 = 2'd3;

  // result word, row_index in the low bits
  typedef struct packed {
    logic [TALLY_W-1:0]   dirty_total;
    logic                 row_changed;
    logic [ROW_IDX_W-1:0] row_index;
  } result_t;

  localparam int RESULT_W    = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // clears the n low bits of each RGB565 channel
  function automatic logic [PIX_W-1:0] channel_mask(input logic [1:0] level);
    logic [PIX_W-1:0] m;
    case (level)
      NOISE_NONE: m = 16'hFFFF;
      NOISE_LOW1: m = 16'hF7DE;
      NOISE_LOW2: m = 16'hE79C;
      NOISE_LOW3: m = 16'hC718;
      default:    m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/drd_cfg.sv -----
module drd_cfg #(
  parameter int MAX_WIDTH  = drd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
  output logic [drd_pkg::PIX_W-1:0]           mask
);
  import drd_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int HCMP = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] row_width;
  logic [CFG_DATA_W-1:0] row_count;
  logic [1:0]            noise_level;

  logic [WCMP-1:0] width_ext;
  logic [HCMP-1:0] height_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= ROW_WIDTH_RST;
      row_count   <= ROW_COUNT_RST;
      noise_level <= NOISE_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH:   row_width   <= cfg_data;
        REG_ROW_COUNT:   row_count   <= cfg_data;
        REG_NOISE_LEVEL: noise_level <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // saturate sizes to [MIN_SIZE, MAX]
  always_comb begin
    width_ext  = WCMP'(row_width);
    height_ext = HCMP'(row_count);
    if (width_ext < WCMP'(MIN_SIZE)) begin
      width_eff = WW'(MIN_SIZE);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
    if (height_ext < HCMP'(MIN_SIZE)) begin
      height_eff = HW'(MIN_SIZE);
    end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_ext);
    end
  end

  assign mask = channel_mask(noise_level);

endmodule

// ----- hdl/drd_line_buf.sv -----
module drd_line_buf #(
  parameter int DEPTH = 2 * drd_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [drd_pkg::PIX_W-1:0]    wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [drd_pkg::PIX_W-1:0]    rdata
);
  import drd_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/drd_frame_store.sv -----
module drd_frame_store #(
  parameter int MAX_WIDTH  = drd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  output logic                                     clearing,
  input  logic                                     re,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  raddr,
  output logic [drd_pkg::PIX_W-1:0]                rdata,
  input  logic                                     we,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  waddr,
  input  logic [drd_pkg::PIX_W-1:0]                wdata
);
  import drd_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PIX_W-1:0] mem_wdata;

  // fill with all ones after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = clearing | we;
    mem_waddr = clearing ? clr_addr : waddr;
    mem_wdata = clearing ? PIXEL_ONES : wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/drd_copy.sv -----
module drd_copy #(
  parameter int MAX_WIDTH  = drd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  output logic                                     ready,
  input  logic                                     start,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  start_base,
  input  logic [$clog2(MAX_WIDTH)-1:0]             start_last,
  input  logic                                     start_bank,
  input  logic                                     commit_valid,
  input  logic                                     commit,
  output logic                                     lb_re,
  output logic [$clog2(MAX_WIDTH):0]               lb_raddr,
  input  logic [drd_pkg::PIX_W-1:0]                lb_rdata,
  output logic                                     fs_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  fs_waddr,
  output logic [drd_pkg::PIX_W-1:0]                fs_wdata
);
  import drd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int FAW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic           rd_active;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  last;
  logic [FAW-1:0] base;
  logic           bank;
  logic           wr_pending;
  logic [FAW-1:0] wr_addr;
  logic           keep;

  // the sweep starts on the row's last pixel; whether it lands is known in the next cycle
  assign ready    = !rd_active || (idx == last);
  assign lb_re    = rd_active;
  assign lb_raddr = {bank, idx};
  assign fs_we    = wr_pending && keep;
  assign fs_waddr = wr_addr;
  assign fs_wdata = lb_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active  <= 1'b0;
      wr_pending <= 1'b0;
      keep       <= 1'b0;
    end else begin
      wr_pending <= rd_active;
      if (commit_valid) begin
        keep <= commit;
      end
      if (start) begin
        rd_active <= 1'b1;
      end else if (rd_active && idx == last) begin
        rd_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= base + FAW'(idx);
    if (start) begin
      idx  <= '0;
      last <= start_last;
      base <= start_base;
      bank <= start_bank;
    end else if (rd_active) begin
      idx <= idx + CW'(1);
    end
  end

endmodule

// ----- hdl/dirty_row_detector.sv -----
// Dirty-row detector for an RGB565 frame streamed in raster order. Each pixel is
// compared, under the noise mask, with the stored previous frame; one result per
// row comes out of the output register after the compare stage: row index, whether
// the row changed, the running dirty-row count and frame_done on m_tlast. A changed row is
// copied from a two-bank line buffer into the frame store by a sweep engine that
// runs alongside the next row. Pixels are taken one per clock. The last pixel of a
// row waits while an untaken result sits in the output register, and while the copy
// sweep of the previous row has more than one pixel left (only when a row is
// shorter than the one before). After reset the frame store is filled with all
// ones, one entry per cycle, with s_tready low until all MAX_WIDTH*MAX_HEIGHT
// entries are written; configuration writes are taken throughout.
module dirty_row_detector #(
  parameter int MAX_WIDTH  = drd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [drd_pkg::PIX_W-1:0]         s_tdata,   // [15:0] pixel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [drd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [8:0] row_index, [9] row_changed,
                                                       // [19:10] dirty_rows_so_far
  output logic                              m_tlast,   // frame_done
  input  logic                              cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import drd_pkg::*;

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_HEIGHT);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int FAW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int LAW      = CW + 1;
  localparam int LB_DEPTH = 2 ** LAW;

  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [PIX_W-1:0] mask;

  logic             fs_clearing;
  logic             fs_re;
  logic [FAW-1:0]   fs_raddr;
  logic [PIX_W-1:0] fs_rdata;
  logic             fs_we;
  logic [FAW-1:0]   fs_waddr;
  logic [PIX_W-1:0] fs_wdata;

  logic             lb_re;
  logic [LAW-1:0]   lb_raddr;
  logic [PIX_W-1:0] lb_rdata;

  logic             cp_ready;

  // position state
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [FAW-1:0]   row_base;
  logic             bank;
  logic             differs;
  logic [TALLY_W-1:0] dirty_tally;

  // compare stage
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [PIX_W-1:0] s1_mask;
  logic             s1_end;
  logic             s1_frame_end;
  logic [RW-1:0]    s1_row;

  result_t          m_result;

  logic             acc;
  logic             row_end;
  logic             frame_end;
  logic             pix_diff;
  logic             changed;
  logic             row_done;

  drd_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .mask       (mask)
  );

  drd_frame_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_frame_store (
    .clk      (clk),
    .rst      (rst),
    .clearing (fs_clearing),
    .re       (fs_re),
    .raddr    (fs_raddr),
    .rdata    (fs_rdata),
    .we       (fs_we),
    .waddr    (fs_waddr),
    .wdata    (fs_wdata)
  );

  drd_line_buf #(.DEPTH(LB_DEPTH)) u_line_buf (
    .clk   (clk),
    .we    (acc),
    .waddr ({bank, col}),
    .wdata (s_tdata),
    .re    (lb_re),
    .raddr (lb_raddr),
    .rdata (lb_rdata)
  );

  drd_copy #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_copy (
    .clk          (clk),
    .rst          (rst),
    .ready        (cp_ready),
    .start        (acc && row_end),
    .start_base   (row_base),
    .start_last   (col),
    .start_bank   (bank),
    .commit_valid (row_done),
    .commit       (changed),
    .lb_re        (lb_re),
    .lb_raddr     (lb_raddr),
    .lb_rdata     (lb_rdata),
    .fs_we        (fs_we),
    .fs_waddr     (fs_waddr),
    .fs_wdata     (fs_wdata)
  );

  assign row_end   = (WW'(col) + WW'(1)) >= width_eff;
  assign frame_end = (HW'(row) + HW'(1)) >= height_eff;

  // a row end needs a free output register and a copy engine that can restart
  assign s_tready = !fs_clearing &&
                    !(row_end && (!cp_ready || (m_tvalid && !m_tready) ||
                                  (s1_valid && s1_end)));
  assign acc      = s_tvalid && s_tready;
  assign fs_re    = acc;
  assign fs_raddr = row_base + FAW'(col);

  assign pix_diff = |((s1_pix ^ fs_rdata) & s1_mask);
  assign changed  = differs | pix_diff;
  assign row_done = s1_valid && s1_end;

  assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, m_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
      bank     <= 1'b0;
    end else if (acc) begin
      if (!row_end) begin
        col <= col + CW'(1);
      end else begin
        col  <= '0;
        bank <= !bank;
        if (frame_end) begin
          row      <= '0;
          row_base <= '0;
        end else begin
          row      <= row + RW'(1);
          row_base <= row_base + FAW'(MAX_WIDTH);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pix       <= s_tdata;
    s1_mask      <= mask;
    s1_end       <= row_end;
    s1_frame_end <= frame_end;
    s1_row       <= row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      differs     <= 1'b0;
      dirty_tally <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      s1_valid <= acc;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s1_valid) begin
        if (s1_end) begin
          differs  <= 1'b0;
          m_tvalid <= 1'b1;
          if (s1_frame_end) begin
            dirty_tally <= '0;
          end else begin
            dirty_tally <= dirty_tally + TALLY_W'(changed);
          end
        end else begin
          differs <= changed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      m_result.row_index   <= ROW_IDX_W'(s1_row);
      m_result.row_changed <= changed;
      m_result.dirty_total <= dirty_tally + TALLY_W'(changed);
      m_tlast              <= s1_frame_end;
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    row_done |-> !m_tvalid)
    else $error("row result would overwrite an untaken result");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (fs_we && fs_re) |-> (fs_waddr != fs_raddr))
    else $error("row copy writes the entry being compared");

  a_tally_cleared: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (dirty_tally == '0))
    else $error("dirty count not cleared at frame end");

  a_copy_start: assert property (@(posedge clk) disable iff (rst)
    (acc && row_end) |=> !$past(fs_clearing))
    else $error("row copy started during frame store fill");
`endif

endmodule
